/* rtl/core/lzw_encoder_top_macros.svh */
// Assertion macros for the LZW encoder RTL.
// Used by lzw_encoder_top; no other dependencies.
`ifndef LZW_ENCODER_TOP_MACROS_SVH
`define LZW_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LZWE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzwe check failed");
`define LZWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzwe check failed");
`else
`define LZWE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LZWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/lzwe_pkg.sv */
// Shared types, sizes and the slot hash of the LZW encoder.
// No dependencies; imported by lzw_encoder_top.
package lzwe_pkg;

  localparam int DICT_SIZE   = 4096;
  localparam int TABLE_DEPTH = 8192;

  localparam int CODE_W  = $clog2(DICT_SIZE);
  localparam int NFC_W   = CODE_W + 1;
  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int SYM_W   = 8;
  localparam int OCODE_W = 16;
  localparam int CFG_W   = 13;
  localparam int CMP_W   = (NFC_W > CFG_W) ? NFC_W : CFG_W;
  localparam int EPOCH_W = 3;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX     = '1;
  localparam logic [CFG_W-1:0]   LIMIT_RESET   = CFG_W'(4096);
  localparam logic [NFC_W-1:0]   FIRST_FREE    = NFC_W'(256);
  localparam logic [31:0]        HASH_MULT     = 32'h9E37_79B1;
  localparam int                 HASH_SHIFT    = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_FINAL
  } lzwe_state_t;

  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [CODE_W-1:0]  pre;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  code;
  } lzwe_entry_t;

  localparam int ENTRY_W = $bits(lzwe_entry_t);

  function automatic logic [TBL_AW-1:0] hash_idx(input logic [CODE_W-1:0] pre,
                                                 input logic [SYM_W-1:0] sym);
    logic [31:0] key;
    logic [31:0] prod;
    key  = {8'b0, 16'(pre), sym};
    prod = key * HASH_MULT;
    return prod[HASH_SHIFT +: TBL_AW];
  endfunction

endpackage

/* rtl/core/lzwe_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lzw_encoder_top.sv */
// LZW encoder top level: byte stream in, 16-bit codes out.
// Depends on lzwe_pkg, lzwe_ram and lzw_encoder_top_macros.svh.
//
//   channel | ports              | word
//   --------+--------------------+-------------------------------------------
//   in      | in_tvalid/tready   | tdata[7:0] symbol, tlast end_of_stream
//   out     | out_tvalid/tready  | tdata[15:0] code, tlast final_code
//   cfg     | cfg_valid/ready    | cfg_data[12:0] dict_limit
//
// An item goes through accept, dictionary read and compare/insert, and each extra
// linear probe repeats the read and compare; the single dictionary RAM port sets this.
// End of stream adds a flush step. After reset, and after every eighth stream (epoch tag
// wrap), a clearing pass over all TABLE_DEPTH entries runs with in_tready low. A two-word
// output queue decouples the result side; a code push holds while it is full.
`include "lzw_encoder_top_macros.svh"

module lzw_encoder_top
  import lzwe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] symbol
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [15:0] code
  output logic               out_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data    // [12:0] dict_limit
);

  lzwe_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]   limit_r;
  logic [CODE_W-1:0]  prefix_r, prefix_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic [NFC_W-1:0]   nfc_r, nfc_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [TBL_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [TBL_AW-1:0]  probe_r, probe_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               eos_r, eos_nxt;

  logic               accept;
  logic               ram_we;
  logic [TBL_AW-1:0]  ram_addr;
  lzwe_entry_t        ram_wdata;
  lzwe_entry_t        ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic               slot_live;
  logic               hit;
  logic               may_insert;

  logic               push;
  logic [OCODE_W-1:0] push_code;
  logic               push_fin;
  logic               pop;
  logic               space;
  logic [OCODE_W-1:0] q_code_r [2];
  logic               q_fin_r  [2];
  logic               q_wr_r;
  logic               q_rd_r;
  logic [1:0]         q_cnt_r;

  lzwe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rbits)
  );

  assign ram_rdata  = lzwe_entry_t'(ram_rbits);
  assign slot_live  = ram_rdata.valid && (ram_rdata.epoch == epoch_r);
  assign hit        = slot_live && (ram_rdata.pre == prefix_r) && (ram_rdata.sym == sym_r);
  assign may_insert = CMP_W'(nfc_r) < ((CMP_W'(limit_r) > CMP_W'(DICT_SIZE)) ?
                                       CMP_W'(DICT_SIZE) : CMP_W'(limit_r));

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign pop        = out_tvalid && out_tready;
  assign space      = (q_cnt_r != 2'd2);
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_code_r[q_rd_r];
  assign out_tlast  = q_fin_r[q_rd_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (pvalid_r) state_nxt = ST_LOOKUP;
          else if (in_tlast) state_nxt = ST_FINAL;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit || (!slot_live && space)) begin
          state_nxt = eos_r ? ST_FINAL : ST_IDLE;
        end else if (slot_live) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_FINAL: begin
        if (space) state_nxt = (epoch_r == EPOCH_MAX) ? ST_CLEAR : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    prefix_nxt   = prefix_r;
    pvalid_nxt   = pvalid_r;
    nfc_nxt      = nfc_r;
    epoch_nxt    = epoch_r;
    clr_addr_nxt = clr_addr_r;
    probe_nxt    = probe_r;
    sym_nxt      = sym_r;
    eos_nxt      = eos_r;
    ram_we       = 1'b0;
    ram_addr     = probe_r;
    ram_wdata    = '0;
    push         = 1'b0;
    push_code    = OCODE_W'(prefix_r);
    push_fin     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          sym_nxt   = in_tdata;
          eos_nxt   = in_tlast;
          probe_nxt = hash_idx(prefix_r, in_tdata);
          if (!pvalid_r) begin
            prefix_nxt = CODE_W'(in_tdata);
            pvalid_nxt = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
      end
      ST_CHECK: begin
        if (hit) begin
          prefix_nxt = ram_rdata.code;
        end else if (!slot_live) begin
          if (space) begin
            push = 1'b1;
            if (may_insert) begin
              ram_we          = 1'b1;
              ram_wdata.valid = 1'b1;
              ram_wdata.epoch = epoch_r;
              ram_wdata.pre   = prefix_r;
              ram_wdata.sym   = sym_r;
              ram_wdata.code  = nfc_r[CODE_W-1:0];
              nfc_nxt         = nfc_r + 1'b1;
            end
            prefix_nxt = CODE_W'(sym_r);
          end
        end else begin
          probe_nxt = probe_r + 1'b1;
        end
      end
      ST_FINAL: begin
        if (space) begin
          push       = 1'b1;
          push_fin   = 1'b1;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
          nfc_nxt    = FIRST_FREE;
          epoch_nxt  = epoch_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      limit_r    <= LIMIT_RESET;
      prefix_r   <= '0;
      pvalid_r   <= 1'b0;
      nfc_r      <= FIRST_FREE;
      epoch_r    <= '0;
      clr_addr_r <= '0;
      q_wr_r     <= 1'b0;
      q_rd_r     <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      prefix_r   <= prefix_nxt;
      pvalid_r   <= pvalid_nxt;
      nfc_r      <= nfc_nxt;
      epoch_r    <= epoch_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (push) q_wr_r <= ~q_wr_r;
      if (pop)  q_rd_r <= ~q_rd_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    sym_r   <= sym_nxt;
    eos_r   <= eos_nxt;
    if (push) begin
      q_code_r[q_wr_r] <= push_code;
      q_fin_r[q_wr_r]  <= push_fin;
    end
  end

  `LZWE_ASSERT_SAME(a_queue_room, clk, rst_n, push, q_cnt_r != 2'd2)
  `LZWE_ASSERT_SAME(a_insert_empty_slot, clk, rst_n, (state_r == ST_CHECK) && ram_we, !slot_live)
  `LZWE_ASSERT_SAME(a_code_range, clk, rst_n, 1'b1, CMP_W'(nfc_r) <= CMP_W'(DICT_SIZE))
  `LZWE_ASSERT_NEXT(a_flush_resets, clk, rst_n, (state_r == ST_FINAL) && push, !pvalid_r && (nfc_r == FIRST_FREE))

endmodule

/* verif/tb_lzw_encoder_top.sv */
// Self-checking testbench for lzw_encoder_top: byte words in, 16-bit code words out.
// Predicts each code with its own hashed dictionary and checks the result stream in order.
// Depends on lzwe_pkg and lzw_encoder_top.
`timescale 1ns / 1ps

module tb_lzw_encoder_top;
  import lzwe_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 300;

  typedef struct {
    logic [7:0] sym;
    logic       eos;
  } byte_word_t;

  typedef struct {
    logic [15:0] code;
    logic        fin;
  } code_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  byte_word_t pending_symbols[$];
  code_word_t expected_codes[$];
  int fail_count = 0;
  int codes_seen = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;
  logic steady = 1'b0;

  // dictionary mirror; a slot is live when its stamp equals the current stream number
  logic [CFG_W-1:0] dict_limit = CFG_W'(4096);
  logic [11:0] prefix = '0;
  bit prefix_held = 0;
  logic [12:0] free_code = 13'd256;
  int stream_no = 1;
  int slot_stream[TABLE_DEPTH];
  logic [11:0] slot_pre[TABLE_DEPTH];
  logic [7:0] slot_sym[TABLE_DEPTH];
  logic [11:0] slot_code[TABLE_DEPTH];

  always #4 clk = ~clk;

  lzw_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic encode_symbol(input logic [7:0] sym, input logic eos);
    logic [31:0] prod;
    logic [12:0] idx;
    logic [12:0] free_slot;
    logic [11:0] found;
    logic [12:0] cap;
    bit hit;
    bit free_found;
    int n;
    hit = 0;
    free_found = 0;
    free_slot = '0;
    found = '0;
    if (!prefix_held) begin
      prefix = 12'(sym);
      prefix_held = 1;
    end else begin
      prod = {12'h000, prefix, sym} * 32'h9E37_79B1;
      idx = prod[19:7];
      for (n = 0; n < TABLE_DEPTH && !hit && !free_found; n++) begin
        if (slot_stream[idx] != stream_no) begin
          free_found = 1;
          free_slot = idx;
        end else if (slot_pre[idx] == prefix && slot_sym[idx] == sym) begin
          hit = 1;
          found = slot_code[idx];
        end else begin
          idx = idx + 13'd1;
        end
      end
      if (hit) begin
        prefix = found;
      end else begin
        cap = (dict_limit > CFG_W'(DICT_SIZE)) ? CFG_W'(DICT_SIZE) : dict_limit;
        expected_codes.insert(expected_codes.size(), '{code: {4'h0, prefix}, fin: 1'b0});
        if (free_code < cap && free_found) begin
          slot_stream[free_slot] = stream_no;
          slot_pre[free_slot] = prefix;
          slot_sym[free_slot] = sym;
          slot_code[free_slot] = free_code[11:0];
          free_code = free_code + 13'd1;
        end
        prefix = 12'(sym);
      end
    end
    if (eos) begin
      expected_codes.insert(expected_codes.size(), '{code: {4'h0, prefix}, fin: 1'b1});
      stream_no++;
      prefix = '0;
      prefix_held = 0;
      free_code = 13'd256;
    end
  endtask

  task automatic push_item(input logic [7:0] sym, input logic eos);
    pending_symbols.insert(pending_symbols.size(), '{sym: sym, eos: eos});
  endtask

  task automatic queue_streams(input int count);
    int n;
    int k;
    int len;
    int span;
    logic [7:0] base;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(400, 100) : $urandom_range(60, 1);
      base = 8'($urandom);
      case ($urandom_range(4))
        0: span = 1;
        1: span = 2;
        2: span = 4;
        3: span = 16;
        default: span = 256;
      endcase
      for (k = 0; k < len && n < count; k++) begin
        push_item(base + 8'($urandom_range(span - 1)), k == len - 1);
        n++;
      end
    end
  endtask

  task automatic settle();
    while (pending_symbols.size() != 0 || in_tvalid || expected_codes.size() != 0 ||
           !in_tready)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    dict_limit = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : drive_bytes
    byte_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_symbol(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_symbols.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
          nxt = pending_symbols.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.sym;
          in_tlast <= nxt.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect_codes
    code_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          $error("unexpected code word %h (final %b)", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_codes.pop_front();
          if (out_tdata !== want.code) begin
            $error("code: expected %h, got %h", want.code, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.fin) begin
            $error("final_code: expected %b, got %b", want.fin, out_tlast);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && codes_seen >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_lzw_encoder_top: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : run_stimulus
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // single byte streams, repeated pairs, runs of one byte
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    for (k = 0; k < 7; k++) push_item((k % 2 == 0) ? 8'h41 : 8'h42, k == 6);
    for (k = 0; k < 5; k++) push_item(8'hFF, k == 4);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h00, 1'b1);
    settle();

    set_limit(CFG_W'(0));
    queue_streams(200);
    settle();
    set_limit(CFG_W'(256));
    queue_streams(200);
    settle();
    set_limit(CFG_W'(257));
    queue_streams(200);
    settle();
    steady <= 1'b1;
    set_limit(CFG_W'(4096));
    queue_streams(200);
    settle();
    steady <= 1'b0;
    // lower the limit while a stream may still be open
    set_limit(CFG_W'(300));
    queue_streams(200);
    settle();
    set_limit(CFG_W'(1000));
    queue_streams(200);
    settle();
    set_limit(CFG_W'(4095));
    queue_streams(200);
    settle();

    // one long stream with the limit above the dictionary size
    set_limit(CFG_W'(8191));
    for (k = 0; k < 260; k++) push_item(8'($urandom), k == 259);
    queue_streams(20);
    settle();

    if (expected_codes.size() != 0) begin
      $error("%0d code words never arrived", expected_codes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_lzw_encoder_top: PASS");
    end else begin
      $display("tb_lzw_encoder_top: FAIL");
    end
    $finish;
  end

endmodule
